// File: hw/rtl/tick_timeout_wakeup_scheduler_unit_defines.svh
// ----------------------------------------------------------------------------
// tick scheduler assertion macros
// concurrent check helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef TICK_TIMEOUT_WAKEUP_SCHEDULER_UNIT_DEFINES_SVH
`define TICK_TIMEOUT_WAKEUP_SCHEDULER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: hw/rtl/ttws_pkg.sv
// ----------------------------------------------------------------------------
// tick scheduler package
// shared types, codes and a helper function of the tick scheduler
// ----------------------------------------------------------------------------
package ttws_pkg;

    localparam int DATA_W    = 32;
    localparam int WEIGHT_W  = 16;
    localparam int TID_W     = 5;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 112;

    localparam logic [DATA_W-1:0] SIGN_BIT = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_CHARGE_SUB,
        ST_CHARGE_ADD,
        ST_FINISH
    } t_state;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_ARM    = 2'd1,
        MODE_CANCEL = 2'd2,
        MODE_WEIGHT = 2'd3
    } t_mode;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic wt_we;
        logic cr_we;
    } t_tbl_ctl;

    function automatic logic [TID_W-1:0] lowest_set(input logic [DATA_W-1:0] m);
        logic [TID_W-1:0] idx;
        idx = '0;
        for (int i = DATA_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = TID_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: hw/rtl/ttws_alu.sv
// ----------------------------------------------------------------------------
// tick scheduler shared adder
// one 32-bit add/subtract unit used for deadline compare and credit update
// ----------------------------------------------------------------------------
module ttws_alu (
    input  logic [ttws_pkg::DATA_W-1:0] i_a,
    input  logic [ttws_pkg::DATA_W-1:0] i_b,
    input  ttws_pkg::t_alu_op           i_op,
    output logic [ttws_pkg::DATA_W-1:0] o_y
);

    always_comb begin
        unique case (i_op)
            ttws_pkg::ALU_ADD: o_y = i_a + i_b;
            ttws_pkg::ALU_SUB: o_y = i_a - i_b;
            default:           o_y = i_a + i_b;
        endcase
    end

endmodule

// File: hw/rtl/ttws_dl_ram.sv
// ----------------------------------------------------------------------------
// tick scheduler deadline store
// one write port, one registered read port
// ----------------------------------------------------------------------------
module ttws_dl_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [ttws_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [ttws_pkg::DATA_W-1:0] o_rdata
);

    logic [ttws_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [ttws_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/ttws_table.sv
// ----------------------------------------------------------------------------
// tick scheduler thread table
// per-thread credit and weight stores with valid bits, reset reads as zero
// ----------------------------------------------------------------------------
module ttws_table #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ttws_pkg::t_tbl_ctl            i_ctl,
    input  logic [AW-1:0]                 i_wt_addr,
    input  logic [ttws_pkg::WEIGHT_W-1:0] i_wt_wdata,
    input  logic [AW-1:0]                 i_cr_addr,
    input  logic [ttws_pkg::DATA_W-1:0]   i_cr_wdata,
    output logic [ttws_pkg::DATA_W-1:0]   o_credit,
    output logic [ttws_pkg::WEIGHT_W-1:0] o_weight
);

    logic [ttws_pkg::DATA_W-1:0]   r_cr_mem [DEPTH];
    logic [ttws_pkg::WEIGHT_W-1:0] r_wt_mem [DEPTH];
    logic [DEPTH-1:0]              r_cr_vld;
    logic [DEPTH-1:0]              r_wt_vld;
    logic [ttws_pkg::DATA_W-1:0]   r_cr_q;
    logic [ttws_pkg::WEIGHT_W-1:0] r_wt_q;
    logic                          r_cr_qv;
    logic                          r_wt_qv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr_vld <= '0;
            r_wt_vld <= '0;
            r_cr_qv  <= 1'b0;
            r_wt_qv  <= 1'b0;
        end else begin
            if (i_ctl.cr_we) begin
                r_cr_vld[i_cr_addr] <= 1'b1;
            end
            if (i_ctl.wt_we) begin
                r_wt_vld[i_wt_addr] <= 1'b1;
            end
            r_cr_qv <= r_cr_vld[i_cr_addr];
            r_wt_qv <= r_wt_vld[i_cr_addr];
        end
    end

    // credit and weight are both read for the charged thread
    always_ff @(posedge i_clk) begin
        if (i_ctl.cr_we) begin
            r_cr_mem[i_cr_addr] <= i_cr_wdata;
        end
        if (i_ctl.wt_we) begin
            r_wt_mem[i_wt_addr] <= i_wt_wdata;
        end
        r_cr_q <= r_cr_mem[i_cr_addr];
        r_wt_q <= r_wt_mem[i_cr_addr];
    end

    assign o_credit = r_cr_qv ? r_cr_q : '0;
    assign o_weight = r_wt_qv ? r_wt_q : '0;

endmodule

// File: hw/rtl/tick_timeout_wakeup_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tick timeout wakeup scheduler
// tick engine: timeout wakeup scan, weighted timeshare charge, lowest ready
// ----------------------------------------------------------------------------
// tick request: DISPATCH, SCAN over every thread, CHARGE_SUB, CHARGE_ADD, then FINISH;
//   CHARGE_ADD is skipped when no credit is charged; the scan checks one entry per cycle
// arm, cancel, weight request: DISPATCH, then FINISH
// the result is registered on leaving FINISH, and no new request is taken before
//   the block leaves FINISH; a held result stalls the block
// reset clears tick counter, armed timers, credits and weights; deadlines stay
// ----------------------------------------------------------------------------
`include "tick_timeout_wakeup_scheduler_unit_defines.svh"

module tick_timeout_wakeup_scheduler_unit #(
    parameter int THREADS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ttws_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [ttws_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // thread[4:0], value[36:5], ready_mask[68:37], active_thread[73:69]
    input  logic [ttws_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // mode[1:0]
    input  logic [ttws_pkg::MODE_W-1:0]      i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // woken_mask[31:0], ready_out[63:32], yielded[64], active_not_ready[65],
    // reschedule[66], next_thread[71:67], none_ready[72], tick_count[104:73]
    output logic [ttws_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int TW = $clog2(THREADS);
    localparam logic [TW-1:0] LAST_IDX = TW'(THREADS - 1);
    localparam logic [ttws_pkg::TID_W:0] THREADS_N = (ttws_pkg::TID_W + 1)'(THREADS);

    ttws_pkg::t_state                r_state;
    ttws_pkg::t_state                n_state;
    ttws_pkg::t_mode                 r_mode;
    logic [ttws_pkg::TID_W-1:0]      r_thr;
    logic [ttws_pkg::DATA_W-1:0]     r_val;
    logic [ttws_pkg::DATA_W-1:0]     r_ready;
    logic [ttws_pkg::TID_W-1:0]      r_act;
    logic [ttws_pkg::DATA_W-1:0]     r_tick;
    logic [THREADS-1:0]              r_armed;
    logic [THREADS-1:0]              r_woken;
    logic                            r_yielded;
    logic                            r_not_ready;
    logic [TW-1:0]                   r_idx;
    logic [TW-1:0]                   n_idx;
    logic [ttws_pkg::DATA_W-1:0]     r_acc;
    logic [ttws_pkg::WEIGHT_W-1:0]   r_limit;
    logic                            r_en;
    logic                            r_out_valid;
    logic [ttws_pkg::M_TDATA_W-1:0]  r_out_data;

    logic                            in_accept;
    logic                            out_free;
    logic                            thr_ok;
    logic                            act_ok;
    logic                            wake;
    logic                            dl_we;
    logic [ttws_pkg::DATA_W-1:0]     dl_q;
    logic [ttws_pkg::DATA_W-1:0]     alu_a;
    logic [ttws_pkg::DATA_W-1:0]     alu_b;
    ttws_pkg::t_alu_op               alu_op;
    logic [ttws_pkg::DATA_W-1:0]     alu_y;
    ttws_pkg::t_tbl_ctl              tbl_ctl;
    logic [ttws_pkg::DATA_W-1:0]     cr_wdata;
    logic [ttws_pkg::DATA_W-1:0]     tbl_credit;
    logic [ttws_pkg::WEIGHT_W-1:0]   tbl_weight;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ttws_pkg::ST_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign thr_ok          = {1'b0, r_thr} < THREADS_N;
    assign act_ok          = r_en && ({1'b0, r_act} < THREADS_N);
    assign wake            = (alu_y == '0) || ((alu_y & ttws_pkg::SIGN_BIT) != '0);

    ttws_alu u_alu (
        .i_a  (alu_a),
        .i_b  (alu_b),
        .i_op (alu_op),
        .o_y  (alu_y)
    );

    ttws_dl_ram #(
        .DEPTH (THREADS),
        .AW    (TW)
    ) u_dl_ram (
        .i_clk   (i_clk),
        .i_we    (dl_we),
        .i_waddr (r_thr[TW-1:0]),
        .i_wdata (r_val),
        .i_raddr (n_idx),
        .o_rdata (dl_q)
    );

    ttws_table #(
        .DEPTH (THREADS),
        .AW    (TW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (tbl_ctl),
        .i_wt_addr  (r_thr[TW-1:0]),
        .i_wt_wdata (r_val[ttws_pkg::WEIGHT_W-1:0]),
        .i_cr_addr  (r_act[TW-1:0]),
        .i_cr_wdata (cr_wdata),
        .o_credit   (tbl_credit),
        .o_weight   (tbl_weight)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttws_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        alu_a    = dl_q;
        alu_b    = r_tick;
        alu_op   = ttws_pkg::ALU_SUB;
        dl_we    = 1'b0;
        tbl_ctl  = '0;
        cr_wdata = r_acc;
        unique case (r_state)
            ttws_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = ttws_pkg::ST_DISPATCH;
                end
            end
            ttws_pkg::ST_DISPATCH: begin
                n_idx = '0;
                if (r_mode == ttws_pkg::MODE_TICK) begin
                    n_state = ttws_pkg::ST_SCAN;
                end else begin
                    n_state = ttws_pkg::ST_FINISH;
                    if (thr_ok && r_mode == ttws_pkg::MODE_ARM) begin
                        dl_we = 1'b1;
                    end
                    if (thr_ok && r_mode == ttws_pkg::MODE_WEIGHT) begin
                        tbl_ctl.wt_we = 1'b1;
                    end
                end
            end
            ttws_pkg::ST_SCAN: begin
                n_idx = r_idx + TW'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = ttws_pkg::ST_CHARGE_SUB;
                end
            end
            ttws_pkg::ST_CHARGE_SUB: begin
                alu_a   = tbl_credit;
                alu_b   = ttws_pkg::DATA_W'(tbl_weight);
                n_state = act_ok ? ttws_pkg::ST_CHARGE_ADD : ttws_pkg::ST_FINISH;
            end
            ttws_pkg::ST_CHARGE_ADD: begin
                alu_a         = r_acc;
                alu_b         = ttws_pkg::DATA_W'(r_limit);
                alu_op        = ttws_pkg::ALU_ADD;
                tbl_ctl.cr_we = 1'b1;
                cr_wdata      = r_acc[ttws_pkg::DATA_W-1] ? alu_y : r_acc;
                n_state       = ttws_pkg::ST_FINISH;
            end
            ttws_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = ttws_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ttws_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_armed     <= '0;
            r_out_valid <= 1'b0;
            r_limit     <= ttws_pkg::WEIGHT_W'(1);
            r_en        <= 1'b1;
            r_yielded   <= 1'b0;
            r_not_ready <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_addr == ttws_pkg::CFG_LIMIT) begin
                    r_limit <= i_cfg_data;
                end else if (i_cfg_addr == ttws_pkg::CFG_ENABLE) begin
                    r_en <= i_cfg_data[0];
                end
            end

            if (in_accept) begin
                r_mode      <= ttws_pkg::t_mode'(i_s_axis_tuser);
                r_thr       <= i_s_axis_tdata[4:0];
                r_val       <= i_s_axis_tdata[36:5];
                r_ready     <= i_s_axis_tdata[68:37];
                r_act       <= i_s_axis_tdata[73:69];
                r_woken     <= '0;
                r_yielded   <= 1'b0;
                r_not_ready <= 1'b0;
            end

            r_idx <= n_idx;

            unique case (r_state)
                ttws_pkg::ST_DISPATCH: begin
                    if (r_mode == ttws_pkg::MODE_TICK) begin
                        r_tick <= r_tick + ttws_pkg::DATA_W'(1);
                    end else if (thr_ok && r_mode == ttws_pkg::MODE_ARM) begin
                        r_armed[r_thr[TW-1:0]] <= 1'b1;
                    end else if (thr_ok && r_mode == ttws_pkg::MODE_CANCEL) begin
                        r_armed[r_thr[TW-1:0]] <= 1'b0;
                    end
                end
                ttws_pkg::ST_SCAN: begin
                    if (r_armed[r_idx] && wake) begin
                        r_armed[r_idx] <= 1'b0;
                        r_woken[r_idx] <= 1'b1;
                    end
                end
                ttws_pkg::ST_CHARGE_SUB: begin
                    r_ready <= r_ready | ttws_pkg::DATA_W'(r_woken);
                    r_acc   <= alu_y;
                end
                ttws_pkg::ST_CHARGE_ADD: begin
                    if (r_acc[ttws_pkg::DATA_W-1]) begin
                        if (r_ready[r_act]) begin
                            r_ready[r_act] <= 1'b0;
                            r_yielded      <= 1'b1;
                        end else begin
                            r_not_ready <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (r_state == ttws_pkg::ST_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ttws_pkg::ST_FINISH && out_free) begin
            r_out_data <= {
                7'd0,
                r_tick,
                (r_ready == '0),
                ttws_pkg::lowest_set(r_ready),
                ((r_woken != '0) || r_yielded),
                r_not_ready,
                r_yielded,
                r_ready,
                ttws_pkg::DATA_W'(r_woken)
            };
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `ASSERT_NEVER(a_flag_excl, i_clk, i_rst_n, r_yielded && r_not_ready)
    `ASSERT_IMPL(a_woken_disarmed, i_clk, i_rst_n, r_state == ttws_pkg::ST_FINISH,
        (r_woken & r_armed) == '0)
    `ASSERT_NEXT(a_tick_inc, i_clk, i_rst_n,
        r_state == ttws_pkg::ST_DISPATCH && r_mode == ttws_pkg::MODE_TICK,
        r_tick == $past(r_tick) + 32'd1)
    `ASSERT_NEXT(a_scan_start, i_clk, i_rst_n, r_state == ttws_pkg::ST_DISPATCH, r_idx == '0)

endmodule

// File: tb/tick_timeout_wakeup_scheduler_unit_tb.sv
// ----------------------------------------------------------------------------
// tick scheduler testbench
// drives tick, arm, cancel and weight requests with random gaps and
// backpressure, tracks deadlines, credits and weights in a local scheduler
// model and compares every result field against the predicted value
// ----------------------------------------------------------------------------
module tick_timeout_wakeup_scheduler_unit_tb;

    localparam int LONG_STALL = 400;

    typedef struct packed {
        logic [31:0] tick_count;
        logic        none_ready;
        logic [4:0]  next_thread;
        logic        reschedule;
        logic        active_not_ready;
        logic        yielded;
        logic [31:0] ready_out;
        logic [31:0] woken_mask;
    } t_sched_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [ttws_pkg::CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [ttws_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [ttws_pkg::S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic [ttws_pkg::MODE_W-1:0]    i_s_axis_tuser = '0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [ttws_pkg::M_TDATA_W-1:0] o_m_axis_tdata;

    // scheduler model state
    logic [31:0]   tick_ctr;
    logic [31:0]   deadline_tbl [32];
    logic [31:0]   armed_mask;
    logic [31:0]   credit_tbl [32];
    logic [15:0]   weight_tbl [32];
    logic [15:0]   ts_limit;
    logic          ts_enable;

    t_sched_result pending_results [$];
    int            fail_count = 0;
    bit            src_gaps_on = 1'b1;
    bit            snk_gaps_on = 1'b1;
    bit            long_hold_req = 1'b0;

    tick_timeout_wakeup_scheduler_unit #(
        .THREADS(32)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_sched_result predict_sched_step(
        input ttws_pkg::t_mode mode,
        input logic [4:0]      thr,
        input logic [31:0]     val,
        input logic [31:0]     rdy,
        input logic [4:0]      act
    );
        t_sched_result res;
        logic [31:0]   woken;
        logic [31:0]   gap;
        logic          yld;
        logic          nrdy;
        bit            found;
        woken = '0;
        yld = 1'b0;
        nrdy = 1'b0;
        if (mode == ttws_pkg::MODE_TICK) begin
            tick_ctr = tick_ctr + 32'd1;
            for (int j = 0; j < 32; j++) begin
                if (armed_mask[j]) begin
                    gap = deadline_tbl[j] - tick_ctr;
                    // wrap-safe: reached when the signed gap is zero or below
                    if (gap == 32'd0 || gap[31]) begin
                        armed_mask[j] = 1'b0;
                        rdy[j] = 1'b1;
                        woken[j] = 1'b1;
                    end
                end
            end
            if (ts_enable) begin
                credit_tbl[act] = credit_tbl[act] - {16'd0, weight_tbl[act]};
                if (credit_tbl[act][31]) begin
                    credit_tbl[act] = credit_tbl[act] + {16'd0, ts_limit};
                    if (!rdy[act]) begin
                        nrdy = 1'b1;
                    end else begin
                        rdy[act] = 1'b0;
                        yld = 1'b1;
                    end
                end
            end
        end else if (mode == ttws_pkg::MODE_ARM) begin
            deadline_tbl[thr] = val;
            armed_mask[thr] = 1'b1;
        end else if (mode == ttws_pkg::MODE_CANCEL) begin
            armed_mask[thr] = 1'b0;
        end else begin
            weight_tbl[thr] = val[15:0];
        end
        res.woken_mask = woken;
        res.ready_out = rdy;
        res.yielded = yld;
        res.active_not_ready = nrdy;
        res.reschedule = (woken != '0) || yld;
        res.next_thread = '0;
        found = 1'b0;
        for (int j = 0; j < 32; j++) begin
            if (rdy[j] && !found) begin
                res.next_thread = 5'(j);
                found = 1'b1;
            end
        end
        res.none_ready = (rdy == '0);
        res.tick_count = tick_ctr;
        return res;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_sched_result want;
        t_sched_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[$bits(t_sched_result)-1:0];
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: %0h", got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("woken_mask", want.woken_mask, got.woken_mask);
                check_field("ready_out", want.ready_out, got.ready_out);
                check_field("yielded", 32'(want.yielded), 32'(got.yielded));
                check_field("active_not_ready", 32'(want.active_not_ready),
                            32'(got.active_not_ready));
                check_field("reschedule", 32'(want.reschedule), 32'(got.reschedule));
                check_field("next_thread", 32'(want.next_thread),
                            32'(got.next_thread));
                check_field("none_ready", 32'(want.none_ready), 32'(got.none_ready));
                check_field("tick_count", want.tick_count, got.tick_count);
            end
        end
    end

    // result sink with random stalls and one long hold
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else if (snk_gaps_on && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #(20 * 1_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_request(input ttws_pkg::t_mode mode, input logic [4:0] thr,
                                input logic [31:0] val, input logic [31:0] rdy,
                                input logic [4:0] act);
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= ttws_pkg::S_TDATA_W'({act, rdy, val, thr});
        i_s_axis_tuser <= mode;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(predict_sched_step(mode, thr, val, rdy, act));
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ttws_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ttws_pkg::CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == ttws_pkg::CFG_LIMIT) begin
            ts_limit = data;
        end else if (idx == ttws_pkg::CFG_ENABLE) begin
            ts_enable = data[0];
        end
        @(posedge i_clk);
    endtask

    task automatic send_random_request();
        ttws_pkg::t_mode mode;
        logic [31:0]     val;
        logic [31:0]     rdy;
        logic [4:0]      act;
        int              r;
        r = $urandom_range(0, 99);
        mode = (r < 50) ? ttws_pkg::MODE_TICK : (r < 72) ? ttws_pkg::MODE_ARM :
               (r < 82) ? ttws_pkg::MODE_CANCEL : ttws_pkg::MODE_WEIGHT;
        val = $urandom;
        if (mode == ttws_pkg::MODE_ARM) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                val = tick_ctr + $urandom_range(0, 30);
            end else if (r < 8) begin
                val = tick_ctr - $urandom_range(0, 1000);
            end
        end else if (mode == ttws_pkg::MODE_WEIGHT) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                val[15:0] = 16'($urandom_range(0, 64));
            end else if (r < 7) begin
                val[15:0] = '0;
            end
        end
        r = $urandom_range(0, 9);
        rdy = (r < 2) ? 32'h0 : (r < 3) ? 32'hFFFF_FFFF :
              (r < 7) ? $urandom : ($urandom & $urandom & $urandom);
        act = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) :
              5'($urandom_range(0, 31));
        send_request(mode, 5'($urandom_range(0, 31)), val, rdy, act);
    endtask

    task automatic test_idle_ticks();
        send_request(ttws_pkg::MODE_TICK, 5'd0, 32'h0, 32'h0, 5'd0);
        send_request(ttws_pkg::MODE_TICK, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    endtask

    task automatic test_request_modes();
        send_request(ttws_pkg::MODE_ARM, 5'd0, 32'h0, 32'h0, 5'd0);
        send_request(ttws_pkg::MODE_ARM, 5'd31, 32'hFFFF_FFFF, 32'h1, 5'd31);
        send_request(ttws_pkg::MODE_ARM, 5'd5, tick_ctr + 32'd3, 32'h0, 5'd0);
        send_request(ttws_pkg::MODE_CANCEL, 5'd31, 32'hFFFF_FFFF, 32'h8000_0000, 5'd0);
        send_request(ttws_pkg::MODE_WEIGHT, 5'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
        send_request(ttws_pkg::MODE_WEIGHT, 5'd31, 32'h0, 32'h0, 5'd31);
        // thread 0 wakes and then yields, credit stays negative after add-back
        send_request(ttws_pkg::MODE_TICK, 5'd0, 32'h0, 32'h8000_0000, 5'd0);
    endtask

    task automatic test_deadline_wrap();
        send_request(ttws_pkg::MODE_ARM, 5'd7, tick_ctr + 32'h7FFF_FFFF, 32'h0, 5'd1);
        send_request(ttws_pkg::MODE_ARM, 5'd8, tick_ctr + 32'h8000_0001, 32'h0, 5'd1);
        send_request(ttws_pkg::MODE_TICK, 5'd0, 32'h0, 32'h0, 5'd1);
        send_request(ttws_pkg::MODE_TICK, 5'd0, 32'h0, 32'h0, 5'd1);
        send_request(ttws_pkg::MODE_TICK, 5'd0, 32'h0, 32'h0, 5'd1);
        send_request(ttws_pkg::MODE_CANCEL, 5'd7, 32'h0, 32'h0, 5'd1);
    endtask

    task automatic test_timeshare();
        drain_results();
        write_reg(ttws_pkg::CFG_LIMIT, 16'hFFFF);
        send_request(ttws_pkg::MODE_WEIGHT, 5'd2, 32'h0000_0001, 32'h0, 5'd2);
        send_request(ttws_pkg::MODE_TICK, 5'd0, 32'h0, 32'h0000_0004, 5'd2);
        send_request(ttws_pkg::MODE_WEIGHT, 5'd2, 32'h0000_FFFF, 32'h0, 5'd2);
        send_request(ttws_pkg::MODE_TICK, 5'd0, 32'h0, 32'h0, 5'd2);
        drain_results();
        write_reg(ttws_pkg::CFG_ENABLE, 16'h0);
        send_request(ttws_pkg::MODE_TICK, 5'd0, 32'h0, 32'h0000_0004, 5'd2);
        drain_results();
        write_reg(ttws_pkg::CFG_ENABLE, 16'h1);
        write_reg(ttws_pkg::CFG_LIMIT, 16'h0001);
    endtask

    task automatic test_backpressure();
        drain_results();
        src_gaps_on = 1'b0;
        long_hold_req = 1'b1;
        repeat (12) send_random_request();
        drain_results();
        src_gaps_on = 1'b1;
    endtask

    task automatic test_random_phases();
        logic [15:0] limits [6];
        logic        enables [6];
        limits = '{16'd1, 16'hFFFF, 16'd200, 16'($urandom_range(1, 65535)), 16'd50,
                   16'($urandom_range(1, 1000))};
        enables = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        for (int p = 0; p < 6; p++) begin
            // sender pauses until all results are back before reconfiguring
            drain_results();
            write_reg(ttws_pkg::CFG_LIMIT, limits[p]);
            write_reg(ttws_pkg::CFG_ENABLE, {15'd0, enables[p]});
            repeat (180) send_random_request();
        end
    endtask

    task automatic test_steady_stream();
        drain_results();
        write_reg(ttws_pkg::CFG_LIMIT, 16'd300);
        write_reg(ttws_pkg::CFG_ENABLE, 16'd1);
        src_gaps_on = 1'b0;
        snk_gaps_on = 1'b0;
        repeat (150) send_random_request();
    endtask

    initial begin
        tick_ctr = '0;
        armed_mask = '0;
        for (int j = 0; j < 32; j++) begin
            deadline_tbl[j] = '0;
            credit_tbl[j] = '0;
            weight_tbl[j] = '0;
        end
        ts_limit = 16'd1;
        ts_enable = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_ticks();
        test_request_modes();
        test_deadline_wrap();
        test_timeshare();
        test_backpressure();
        test_random_phases();
        test_steady_stream();

        drain_results();
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
